FILE: sv/pdll_pkg.sv
// Package with shared constants, codes and types for the positional list.
package pdll_pkg;

   localparam int CAPACITY_DEF   = 64;
   localparam int DATA_WIDTH_DEF = 32;
   localparam int CMD_W          = 3;
   localparam int POS_W          = 7;
   localparam int OUT_W          = 32;
   localparam int SIZE_W         = 7;
   localparam int STAT_W         = 2;

   typedef enum logic [CMD_W-1:0] {
      CMD_INS_FIRST = 3'd0,
      CMD_INS_LAST  = 3'd1,
      CMD_INS_POS   = 3'd2,
      CMD_DEL_FIRST = 3'd3,
      CMD_DEL_LAST  = 3'd4,
      CMD_DEL_POS   = 3'd5,
      CMD_DISPLAY   = 3'd6,
      CMD_COUNT     = 3'd7
   } cmd_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK     = 2'd0,
      ST_BADPOS = 2'd1,
      ST_EMPTY  = 2'd2,
      ST_FULL   = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_ALLOC,
      S_WALK,
      S_WALKWAIT,
      S_LINK,
      S_UNLINK,
      S_UNLINKWAIT,
      S_HEADWAIT,
      S_DISPREAD,
      S_DISPWAIT,
      S_DISPOUT,
      S_RESULT
   } state_type;

endpackage

FILE: sv/pdll_ram.sv
// Generic single-port-write, single-read RAM with a registered read.
module pdll_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

FILE: sv/pdll_alloc.sv
// Allocation map of slots in use with a lowest-free-slot search.
module pdll_alloc #(
   parameter int CAPACITY = 64
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        set_en,
   input  logic                        clr_en,
   input  logic [$clog2(CAPACITY)-1:0] slot,
   output logic [$clog2(CAPACITY)-1:0] free_slot
);

   localparam int SW = $clog2(CAPACITY);

   logic [CAPACITY-1:0] used_ff;
   logic [SW-1:0]       free_in;

   // Priority search for the lowest free slot, registered for timing.
   always_comb begin
      free_in = '0;
      for (int i = CAPACITY - 1; i >= 0; i--) begin
         if (!used_ff[i]) begin
            free_in = SW'(i);
         end
      end
   end

   // Map update and registered search result.
   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff   <= '0;
         free_slot <= '0;
      end else begin
         if (set_en) begin
            used_ff[slot] <= 1'b1;
         end else if (clr_en) begin
            used_ff[slot] <= 1'b0;
         end
         free_slot <= free_in;
      end
   end

endmodule

FILE: sv/positional_doubly_linked_list.sv
// Insert or delete at an end allocates or unlinks directly; positional commands walk the link
// memory from the head, one link per read step and wait step.
// Display reads each entry in turn and emits one beat per entry, waiting while a beat is held
// by back-pressure; count returns the size in a single result beat.
// One command is in work at a time; req_tready is high only while the controller is idle.
// Synchronous active-high reset clears the list count, head, tail and allocation map;
// the value and link memories are not cleared and are only read along live links.
module positional_doubly_linked_list #(
   parameter int CAPACITY   = pdll_pkg::CAPACITY_DEF,
   parameter int DATA_WIDTH = pdll_pkg::DATA_WIDTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // command [2:0], value [34:3], position [41:35], zero fill [47:42]
   input  logic [47:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // entry_data [31:0], size [38:32], status [40:39], zero fill [47:41]
   output logic [47:0] rsp_tdata,
   output logic        rsp_tlast
);

   import pdll_pkg::*;

   localparam int SW = $clog2(CAPACITY);

   state_type state_ff, state_in;
   cmd_type   cmd_ff, cmd_in;
   logic [DATA_WIDTH-1:0] val_ff, val_in;
   logic [POS_W-1:0]      pos_ff, pos_in;
   logic [SW-1:0]  head_ff, head_in, tail_ff, tail_in;
   logic [SIZE_W-1:0] cnt_ff, cnt_in;
   logic [SW-1:0]  cur_ff, cur_in;      // walk pointer
   logic [SW-1:0]  slot_ff, slot_in;    // new slot
   logic [SIZE_W-1:0] idx_ff, idx_in;   // steps left
   status_type     st_ff, st_in;
   logic [OUT_W-1:0] odata_ff, odata_in;
   logic           olast_ff, olast_in;
   logic           ovalid_ff, ovalid_in;
   logic [SW-1:0]  bw_rd_pred_ff;

   // Memory ports.
   logic            fw_we, bw_we, vw_we;
   logic [SW-1:0]   fw_wa, bw_wa, rd_a;
   logic [SW-1:0]   fw_wd, bw_wd, fw_rd, bw_rd;
   logic [DATA_WIDTH-1:0] v_rd;
   logic            a_set, a_clr;
   logic [SW-1:0]   a_slot, free_slot;

   pdll_ram #(.WIDTH(SW), .DEPTH(CAPACITY)) u_fwd (
      .clock, .wr_en(fw_we), .wr_addr(fw_wa), .wr_data(fw_wd), .rd_addr(rd_a), .rd_data(fw_rd));
   pdll_ram #(.WIDTH(SW), .DEPTH(CAPACITY)) u_bwd (
      .clock, .wr_en(bw_we), .wr_addr(bw_wa), .wr_data(bw_wd), .rd_addr(rd_a), .rd_data(bw_rd));
   pdll_ram #(.WIDTH(DATA_WIDTH), .DEPTH(CAPACITY)) u_val (
      .clock, .wr_en(vw_we), .wr_addr(slot_ff), .wr_data(val_ff), .rd_addr(rd_a),
      .rd_data(v_rd));
   pdll_alloc #(.CAPACITY(CAPACITY)) u_alloc (
      .clock, .reset, .set_en(a_set), .clr_en(a_clr), .slot(a_slot), .free_slot);

   logic [SIZE_W-1:0] cap_c;
   logic [POS_W-1:0]  rpos;
   logic [SIZE_W-1:0] cnt1;
   assign cap_c = SIZE_W'(CAPACITY);
   assign rpos  = req_tdata[41:35];
   assign cnt1  = cnt_ff + SIZE_W'(1);

   // Controller: next state, memory controls and results.
   always_comb begin
      state_in = state_ff; cmd_in = cmd_ff; val_in = val_ff; pos_in = pos_ff;
      head_in = head_ff; tail_in = tail_ff; cnt_in = cnt_ff; cur_in = cur_ff;
      slot_in = slot_ff; idx_in = idx_ff; st_in = st_ff;
      odata_in = odata_ff; olast_in = olast_ff; ovalid_in = ovalid_ff;
      fw_we = 1'b0; bw_we = 1'b0; vw_we = 1'b0; fw_wa = '0; bw_wa = '0;
      fw_wd = '0; bw_wd = '0; rd_a = cur_ff; a_set = 1'b0; a_clr = 1'b0; a_slot = slot_ff;
      req_tready = 1'b0;
      if (ovalid_ff && rsp_tready) ovalid_in = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_tready = !ovalid_ff;
            if (req_tvalid && !ovalid_ff) begin
               cmd_in = cmd_type'(req_tdata[2:0]);
               val_in = DATA_WIDTH'($signed(req_tdata[34:3]));
               pos_in = rpos;
               st_in  = ST_OK;
               slot_in = free_slot;
               case (cmd_type'(req_tdata[2:0]))
                  CMD_INS_FIRST, CMD_INS_LAST, CMD_INS_POS: begin
                     if (cnt_ff >= cap_c) begin
                        st_in = ST_FULL; state_in = S_RESULT;
                     end else if (req_tdata[2:0] == CMD_INS_POS &&
                                  (rpos == '0 || SIZE_W'(rpos) > cnt1)) begin
                        st_in = ST_BADPOS; state_in = S_RESULT;
                     end else begin
                        state_in = S_ALLOC;
                     end
                  end
                  CMD_DEL_FIRST, CMD_DEL_LAST, CMD_DEL_POS: begin
                     if (cnt_ff == '0) begin
                        st_in = ST_EMPTY; state_in = S_RESULT;
                     end else if (req_tdata[2:0] == CMD_DEL_POS &&
                                  (rpos == '0 || SIZE_W'(rpos) > cnt_ff)) begin
                        st_in = ST_BADPOS; state_in = S_RESULT;
                     end else if (req_tdata[2:0] == CMD_DEL_FIRST ||
                                  (req_tdata[2:0] == CMD_DEL_POS && rpos == POS_W'(1))) begin
                        cur_in = head_ff; cmd_in = CMD_DEL_FIRST; state_in = S_UNLINK;
                     end else if (req_tdata[2:0] == CMD_DEL_LAST ||
                                  SIZE_W'(rpos) == cnt_ff) begin
                        cur_in = tail_ff; cmd_in = CMD_DEL_LAST; state_in = S_UNLINK;
                     end else begin
                        cur_in = head_ff; idx_in = SIZE_W'(rpos) - SIZE_W'(1);
                        state_in = S_WALK;
                     end
                  end
                  CMD_DISPLAY: begin
                     if (cnt_ff == '0) begin
                        st_in = ST_EMPTY; state_in = S_RESULT;
                     end else begin
                        cur_in = head_ff; idx_in = cnt_ff; state_in = S_DISPREAD;
                     end
                  end
                  default: state_in = S_RESULT;
               endcase
            end
         end
         S_ALLOC: begin
            // Store the value in the new slot and mark it in use.
            vw_we = 1'b1; a_set = 1'b1;
            if (cmd_ff == CMD_INS_FIRST || (cmd_ff == CMD_INS_POS && pos_ff == POS_W'(1)) ||
                cnt_ff == '0) begin
               if (cnt_ff == '0) begin
                  tail_in = slot_ff;
               end else begin
                  fw_we = 1'b1; fw_wa = slot_ff; fw_wd = head_ff;
                  bw_we = 1'b1; bw_wa = head_ff; bw_wd = slot_ff;
               end
               head_in = slot_ff; cnt_in = cnt1; state_in = S_RESULT;
            end else if (cmd_ff == CMD_INS_LAST || SIZE_W'(pos_ff) == cnt1) begin
               bw_we = 1'b1; bw_wa = slot_ff; bw_wd = tail_ff;
               fw_we = 1'b1; fw_wa = tail_ff; fw_wd = slot_ff;
               tail_in = slot_ff; cnt_in = cnt1; state_in = S_RESULT;
            end else begin
               // Walk to the predecessor at index pos-2.
               cur_in = head_ff; idx_in = SIZE_W'(pos_ff) - SIZE_W'(2); state_in = S_WALK;
            end
         end
         S_WALK: begin
            if (idx_ff == '0) begin
               state_in = (cmd_ff == CMD_DEL_POS) ? S_UNLINK : S_LINK;
            end else begin
               state_in = S_WALKWAIT;
            end
            rd_a = cur_ff;
         end
         S_WALKWAIT: begin
            cur_in = fw_rd; idx_in = idx_ff - SIZE_W'(1); state_in = S_WALK;
         end
         S_LINK: begin
            // Read of predecessor links issued; wait for the read data.
            rd_a = cur_ff; state_in = S_HEADWAIT;
         end
         S_HEADWAIT: begin
            if (cmd_ff == CMD_INS_POS) begin
               fw_we = 1'b1; fw_wa = cur_ff; fw_wd = slot_ff;
               bw_we = 1'b1; bw_wa = fw_rd; bw_wd = slot_ff;
               slot_in = fw_rd;
               cnt_in = cnt1;
               // second pass writes the new slot's links
               state_in = S_UNLINKWAIT;
               cur_in = slot_ff;
            end
         end
         S_UNLINK: begin
            rd_a = cur_ff; state_in = S_UNLINKWAIT;
         end
         S_UNLINKWAIT: begin
            if (cmd_ff == CMD_INS_POS) begin
               // The current pointer holds the new slot, the slot register holds the
               // successor, and the predecessor was kept in the previous step.
               fw_we = 1'b1; fw_wa = cur_ff; fw_wd = slot_ff;
               bw_we = 1'b1; bw_wa = cur_ff; bw_wd = bw_rd_pred_ff;
               state_in = S_RESULT;
            end else begin
               a_clr = 1'b1; a_slot = cur_ff; cnt_in = cnt_ff - SIZE_W'(1);
               case (cmd_ff)
                  CMD_DEL_FIRST: if (cnt_ff > SIZE_W'(1)) head_in = fw_rd;
                  CMD_DEL_LAST:  if (cnt_ff > SIZE_W'(1)) tail_in = bw_rd;
                  default: begin
                     fw_we = 1'b1; fw_wa = bw_rd; fw_wd = fw_rd;
                     bw_we = 1'b1; bw_wa = fw_rd; bw_wd = bw_rd;
                  end
               endcase
               state_in = S_RESULT;
            end
         end
         S_DISPREAD: begin
            rd_a = cur_ff; state_in = S_DISPWAIT;
         end
         S_DISPWAIT: begin
            if (!ovalid_ff || rsp_tready) begin
               odata_in = OUT_W'($signed(v_rd));
               olast_in = (idx_ff == SIZE_W'(1));
               ovalid_in = 1'b1;
               cur_in = fw_rd; idx_in = idx_ff - SIZE_W'(1);
               state_in = (idx_ff == SIZE_W'(1)) ? S_IDLE : S_DISPOUT;
            end
         end
         S_DISPOUT: begin
            state_in = S_DISPREAD;
         end
         S_RESULT: begin
            if (!ovalid_ff || rsp_tready) begin
               odata_in = '0; olast_in = 1'b1; ovalid_in = 1'b1; state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Predecessor slot kept for the positional insert link step.
   always_ff @(posedge clock) begin
      if (state_ff == S_HEADWAIT) bw_rd_pred_ff <= cur_ff;
   end

   // Control and payload registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; head_ff <= '0; tail_ff <= '0; cnt_ff <= '0; ovalid_ff <= 1'b0;
      end else begin
         state_ff <= state_in; head_ff <= head_in; tail_ff <= tail_in; cnt_ff <= cnt_in;
         ovalid_ff <= ovalid_in;
      end
      cmd_ff <= cmd_in; val_ff <= val_in; pos_ff <= pos_in; cur_ff <= cur_in;
      slot_ff <= slot_in; idx_ff <= idx_in; st_ff <= st_in;
      odata_ff <= odata_in; olast_ff <= olast_in;
   end

   assign rsp_tvalid = ovalid_ff;
   assign rsp_tlast  = olast_ff;
   assign rsp_tdata  = {7'd0, st_ff, cnt_ff, odata_ff};

   // The count never exceeds the capacity.
   a_cnt: assert property (@(posedge clock) disable iff (reset) cnt_ff <= cap_c)
      else $error("entry count above capacity");
   // A command is taken only while no result is pending.
   a_acc: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |-> !rsp_tvalid)
      else $error("command accepted with result pending");
   // Full status is reported only when the list holds its full capacity.
   a_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && st_ff == ST_FULL) |-> cnt_ff == cap_c)
      else $error("full status with room left");

endmodule
